@@ hw/rtl/bpcq_pkg.sv @@
// ----------------------------------------------------------------------------
// bpcq_pkg
// Shared types and constants for the button pair combo qualifier.
// ----------------------------------------------------------------------------
package bpcq_pkg;

    localparam int BTN_W      = 6;
    localparam int PAIR_W     = 15;
    localparam int PAIR_IDX_W = 4;
    localparam int CNT_W      = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_PAIR_WAIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_HOLD  = 1'b1;

    localparam logic [CNT_W-1:0] PAIR_WAIT_RST = 8'd200;
    localparam logic [CNT_W-1:0] TAP_HOLD_RST  = 8'd50;

    typedef struct packed {
        logic [BTN_W-1:0]  buttons;
        logic              layer_changed;
        logic [PAIR_W-1:0] pair_enable;
        logic              qualify_enable;
    } t_in_item;

    typedef struct packed {
        logic [BTN_W-1:0]  buttons_out;
        logic [PAIR_W-1:0] combo_out;
        logic              changed;
    } t_out_item;

endpackage

@@ hw/rtl/bpcq_scan.sv @@
// ----------------------------------------------------------------------------
// bpcq_scan
// Per-scan update: hold and tap counters, pair combo check and report.
// ----------------------------------------------------------------------------
module bpcq_scan #(
    parameter int NUM_BUTTONS = 6
) (
    input  bpcq_pkg::t_in_item                    i_item,
    input  logic [bpcq_pkg::CNT_W-1:0]            i_pair_wait,
    input  logic [bpcq_pkg::CNT_W-1:0]            i_tap_hold,
    input  logic [bpcq_pkg::CNT_W-1:0]            i_hold [NUM_BUTTONS],
    input  logic [bpcq_pkg::CNT_W-1:0]            i_tap  [NUM_BUTTONS],
    input  logic [bpcq_pkg::PAIR_W-1:0]           i_pair_mask,
    input  logic [bpcq_pkg::PAIR_W-1:0]           i_prev_combo,
    input  logic [bpcq_pkg::BTN_W-1:0]            i_prev_buttons,
    output logic [bpcq_pkg::CNT_W-1:0]            o_hold [NUM_BUTTONS],
    output logic [bpcq_pkg::CNT_W-1:0]            o_tap  [NUM_BUTTONS],
    output logic [bpcq_pkg::PAIR_W-1:0]           o_pair_mask,
    output bpcq_pkg::t_out_item                   o_result
);

    logic [bpcq_pkg::BTN_W+NUM_BUTTONS-1:0] raw_x;
    logic [bpcq_pkg::BTN_W+NUM_BUTTONS-1:0] rep_x;
    logic [NUM_BUTTONS-1:0]                 pressed;
    logic [NUM_BUTTONS-1:0]                 member;
    logic [NUM_BUTTONS-1:0]                 forced;
    logic [NUM_BUTTONS-1:0]                 supp;
    logic [NUM_BUTTONS-1:0]                 report;
    logic [bpcq_pkg::PAIR_W-1:0]            pair_m;
    logic [bpcq_pkg::PAIR_W-1:0]            combo;
    logic [bpcq_pkg::BTN_W-1:0]             bout;

    assign raw_x   = {{NUM_BUTTONS{1'b0}}, i_item.buttons};
    assign pressed = raw_x[NUM_BUTTONS-1:0];
    assign pair_m  = i_item.layer_changed ? i_item.pair_enable : i_pair_mask;

    always_comb begin
        int unsigned idx;
        member = '0;
        forced = '0;
        supp   = '0;
        combo  = '0;
        idx    = 0;
        for (int a = 0; a < NUM_BUTTONS; a++) begin
            for (int b = a + 1; b < NUM_BUTTONS; b++) begin
                if (idx < bpcq_pkg::PAIR_W) begin
                    if (pair_m[idx[bpcq_pkg::PAIR_IDX_W-1:0]]) begin
                        member[a] = 1'b1;
                        member[b] = 1'b1;
                        if (i_item.qualify_enable) begin
                            if (pressed[a] && pressed[b]) begin
                                combo[idx[bpcq_pkg::PAIR_IDX_W-1:0]] = 1'b1;
                                forced[a] = 1'b1;
                                forced[b] = 1'b1;
                                supp[a]   = 1'b1;
                                supp[b]   = 1'b1;
                            end else if (i_prev_combo[idx[bpcq_pkg::PAIR_IDX_W-1:0]] &&
                                         (pressed[a] || pressed[b])) begin
                                combo[idx[bpcq_pkg::PAIR_IDX_W-1:0]] = 1'b1;
                                supp[a] = 1'b1;
                                supp[b] = 1'b1;
                            end
                        end
                    end
                end
                idx = idx + 1;
            end
        end
    end

    always_comb begin
        logic [bpcq_pkg::CNT_W-1:0] hl;
        logic [bpcq_pkg::CNT_W-1:0] h;
        logic [bpcq_pkg::CNT_W-1:0] t;
        logic                       r;
        for (int a = 0; a < NUM_BUTTONS; a++) begin
            hl = i_hold[a];
            r  = pressed[a];
            if (i_item.layer_changed && (i_hold[a] > 8'd1)) begin
                r  = 1'b1;
                hl = '0;
            end
            h = hl;
            t = i_tap[a];
            if (i_item.qualify_enable) begin
                if (member[a]) begin
                    if (pressed[a]) begin
                        if (hl != 8'd1) begin
                            r = 1'b0;
                            if (hl == 8'd0) begin
                                h = i_pair_wait;
                                t = '0;
                            end else begin
                                h = hl - 8'd1;
                            end
                        end
                    end else begin
                        if (hl > 8'd1) begin
                            t = i_tap_hold;
                        end
                        h = '0;
                    end
                end
                if (forced[a]) begin
                    h = 8'd1;
                end
                if (supp[a]) begin
                    r = 1'b0;
                end
                if (t != 8'd0) begin
                    t = t - 8'd1;
                    r = 1'b1;
                end
            end
            o_hold[a] = h;
            o_tap[a]  = t;
            report[a] = r;
        end
    end

    assign rep_x       = {{bpcq_pkg::BTN_W{1'b0}}, report};
    assign bout        = rep_x[bpcq_pkg::BTN_W-1:0];
    assign o_pair_mask = pair_m;

    assign o_result.buttons_out = bout;
    assign o_result.combo_out   = combo;
    assign o_result.changed     = (bout != i_prev_buttons) || (combo != i_prev_combo);

endmodule

@@ hw/rtl/button_pair_combo_qualifier.sv @@
// ----------------------------------------------------------------------------
// button_pair_combo_qualifier
// Qualifies button scans into single-button reports and pair combo bits.
// ----------------------------------------------------------------------------
// Path: an accepted item is held in the input register, and the scan update
//   carries it into the result register once that register can advance.
// Throughput: one item per cycle while i_out_ready does not stall the output.
// Reset: synchronous, active low; clears counters, pair mask, previous
//   outputs and valid flags; the pair wait term returns to 200 and the tap
//   term to 50.
module button_pair_combo_qualifier #(
    parameter int NUM_BUTTONS = 6
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  bpcq_pkg::t_in_item                   i_in_item,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output bpcq_pkg::t_out_item                  o_out_item,
    input  logic                                 i_cfg_we,
    input  logic [bpcq_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [bpcq_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    logic [bpcq_pkg::CNT_W-1:0]  r_pair_wait;
    logic [bpcq_pkg::CNT_W-1:0]  r_tap_hold;
    logic                        r_in_valid;
    bpcq_pkg::t_in_item          r_in_item;
    logic                        r_out_valid;
    bpcq_pkg::t_out_item         r_out_item;
    logic [bpcq_pkg::CNT_W-1:0]  r_hold [NUM_BUTTONS];
    logic [bpcq_pkg::CNT_W-1:0]  r_tap  [NUM_BUTTONS];
    logic [bpcq_pkg::PAIR_W-1:0] r_pair_mask;
    logic [bpcq_pkg::PAIR_W-1:0] r_prev_combo;
    logic [bpcq_pkg::BTN_W-1:0]  r_prev_buttons;

    logic [bpcq_pkg::CNT_W-1:0]  n_hold [NUM_BUTTONS];
    logic [bpcq_pkg::CNT_W-1:0]  n_tap  [NUM_BUTTONS];
    logic [bpcq_pkg::PAIR_W-1:0] n_pair_mask;
    bpcq_pkg::t_out_item         n_result;

    logic advance;
    logic fire;

    assign advance     = !r_out_valid || i_out_ready;
    assign fire        = r_in_valid && advance;
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    bpcq_scan #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_scan (
        .i_item         (r_in_item),
        .i_pair_wait    (r_pair_wait),
        .i_tap_hold     (r_tap_hold),
        .i_hold         (r_hold),
        .i_tap          (r_tap),
        .i_pair_mask    (r_pair_mask),
        .i_prev_combo   (r_prev_combo),
        .i_prev_buttons (r_prev_buttons),
        .o_hold         (n_hold),
        .o_tap          (n_tap),
        .o_pair_mask    (n_pair_mask),
        .o_result       (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair_wait <= bpcq_pkg::PAIR_WAIT_RST;
            r_tap_hold  <= bpcq_pkg::TAP_HOLD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bpcq_pkg::CFG_PAIR_WAIT: r_pair_wait <= i_cfg_data;
                bpcq_pkg::CFG_TAP_HOLD:  r_tap_hold  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
        if (fire) begin
            r_out_item <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < NUM_BUTTONS; a++) begin
                r_hold[a] <= '0;
                r_tap[a]  <= '0;
            end
            r_pair_mask    <= '0;
            r_prev_combo   <= '0;
            r_prev_buttons <= '0;
        end else if (fire) begin
            r_hold         <= n_hold;
            r_tap          <= n_tap;
            r_pair_mask    <= n_pair_mask;
            r_prev_combo   <= n_result.combo_out;
            r_prev_buttons <= n_result.buttons_out;
        end
    end

    a_bypass_no_combo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && !r_in_item.qualify_enable |=> o_out_item.combo_out == '0)
        else $error("combo reported while qualification bypassed");

    a_prev_tracks_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> (r_prev_buttons == o_out_item.buttons_out) &&
                 (r_prev_combo == o_out_item.combo_out))
        else $error("previous-scan state out of step with result");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");

endmodule

@@ dv/button_pair_combo_qualifier_tb.sv @@
// ----------------------------------------------------------------------------
// button_pair_combo_qualifier_tb
// Self-checking testbench for the button pair combo qualifier. A scoreboard
// predicts each scan report from the accepted scan item and its own copy of
// the hold and tap counters. Directed scans cover presses, combos, taps,
// layer changes and bypass. Random phases follow at several register
// settings, with random idling on both channels and one long output stall.
// ----------------------------------------------------------------------------
module button_pair_combo_qualifier_tb;
    timeunit 1ns;
    timeprecision 1ps;

    class combo_scoreboard;
        logic [bpcq_pkg::CNT_W-1:0]  pair_wait;
        logic [bpcq_pkg::CNT_W-1:0]  tap_hold;
        logic [bpcq_pkg::CNT_W-1:0]  hold_cnt [bpcq_pkg::BTN_W];
        logic [bpcq_pkg::CNT_W-1:0]  tap_cnt [bpcq_pkg::BTN_W];
        logic [bpcq_pkg::PAIR_W-1:0] pair_mask;
        logic [bpcq_pkg::PAIR_W-1:0] last_combo;
        logic [bpcq_pkg::BTN_W-1:0]  last_buttons;
        bpcq_pkg::t_out_item         pending_reports [$];
        int                          errors;

        function new();
            errors = 0;
            clear();
        endfunction

        function void clear();
            pair_wait = bpcq_pkg::PAIR_WAIT_RST;
            tap_hold  = bpcq_pkg::TAP_HOLD_RST;
            for (int i = 0; i < bpcq_pkg::BTN_W; i++) begin
                hold_cnt[i] = '0;
                tap_cnt[i]  = '0;
            end
            pair_mask    = '0;
            last_combo   = '0;
            last_buttons = '0;
        endfunction

        function void set_reg(logic [bpcq_pkg::CFG_IDX_W-1:0] idx,
                              logic [bpcq_pkg::CFG_DATA_W-1:0] value);
            if (idx == bpcq_pkg::CFG_PAIR_WAIT) begin
                pair_wait = value;
            end else begin
                tap_hold = value;
            end
        endfunction

        function void note_scan(bpcq_pkg::t_in_item scan);
            bpcq_pkg::t_out_item         rpt;
            logic [bpcq_pkg::BTN_W-1:0]  report;
            logic [bpcq_pkg::BTN_W-1:0]  member;
            logic [bpcq_pkg::PAIR_W-1:0] combo;
            int                          idx;
            report = '0;
            member = '0;
            combo  = '0;
            if (scan.layer_changed) begin
                for (int a = 0; a < bpcq_pkg::BTN_W; a++) begin
                    if (hold_cnt[a] > 1) begin
                        report[a]   = 1'b1;
                        hold_cnt[a] = '0;
                    end
                end
                pair_mask = scan.pair_enable;
            end
            idx = 0;
            for (int a = 0; a < bpcq_pkg::BTN_W; a++) begin
                for (int b = a + 1; b < bpcq_pkg::BTN_W; b++) begin
                    if (pair_mask[idx]) begin
                        member[a] = 1'b1;
                        member[b] = 1'b1;
                    end
                    idx++;
                end
            end
            report = report | scan.buttons;
            if (scan.qualify_enable) begin
                for (int a = 0; a < bpcq_pkg::BTN_W; a++) begin
                    if (member[a]) begin
                        if (scan.buttons[a]) begin
                            if (hold_cnt[a] != 1) begin
                                report[a] = 1'b0;
                                if (hold_cnt[a] == 0) begin
                                    hold_cnt[a] = pair_wait;
                                    tap_cnt[a]  = '0;
                                end else begin
                                    hold_cnt[a] = hold_cnt[a] - 1'b1;
                                end
                            end else begin
                                report[a] = 1'b1;
                            end
                        end else begin
                            if (hold_cnt[a] > 1) begin
                                tap_cnt[a] = tap_hold;
                            end
                            hold_cnt[a] = '0;
                        end
                    end
                end
                idx = 0;
                for (int a = 0; a < bpcq_pkg::BTN_W; a++) begin
                    for (int b = a + 1; b < bpcq_pkg::BTN_W; b++) begin
                        if (pair_mask[idx]) begin
                            if (scan.buttons[a] && scan.buttons[b]) begin
                                hold_cnt[a] = 8'd1;
                                hold_cnt[b] = 8'd1;
                                report[a]   = 1'b0;
                                report[b]   = 1'b0;
                                combo[idx]  = 1'b1;
                            end else if (last_combo[idx] &&
                                         (scan.buttons[a] || scan.buttons[b])) begin
                                combo[idx] = 1'b1;
                                report[a]  = 1'b0;
                                report[b]  = 1'b0;
                            end
                        end
                        idx++;
                    end
                end
                for (int a = 0; a < bpcq_pkg::BTN_W; a++) begin
                    if (tap_cnt[a] > 0) begin
                        tap_cnt[a] = tap_cnt[a] - 1'b1;
                        report[a]  = 1'b1;
                    end
                end
            end
            rpt.buttons_out = report;
            rpt.combo_out   = combo;
            rpt.changed     = (report != last_buttons) || (combo != last_combo);
            last_buttons    = report;
            last_combo      = combo;
            pending_reports.push_back(rpt);
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            $display("mismatch %s: got 0x%0h, want 0x%0h at %0t ns", what, got, want, $time);
        endtask

        task check_report(bpcq_pkg::t_out_item got);
            bpcq_pkg::t_out_item want;
            if (pending_reports.size() == 0) begin
                report_mismatch("item with nothing pending", 32'(got), 32'd0);
                return;
            end
            want = pending_reports.pop_front();
            if (got.buttons_out !== want.buttons_out) begin
                report_mismatch("buttons_out", 32'(got.buttons_out), 32'(want.buttons_out));
            end
            if (got.combo_out !== want.combo_out) begin
                report_mismatch("combo_out", 32'(got.combo_out), 32'(want.combo_out));
            end
            if (got.changed !== want.changed) begin
                report_mismatch("changed", 32'(got.changed), 32'(want.changed));
            end
        endtask
    endclass

    logic                            i_clk       = 1'b0;
    logic                            i_rst_n     = 1'b0;
    logic                            i_in_valid  = 1'b0;
    logic                            o_in_ready;
    bpcq_pkg::t_in_item              i_in_item   = '0;
    logic                            o_out_valid;
    logic                            i_out_ready = 1'b0;
    bpcq_pkg::t_out_item             o_out_item;
    logic                            i_cfg_we    = 1'b0;
    logic [bpcq_pkg::CFG_IDX_W-1:0]  i_cfg_idx   = bpcq_pkg::CFG_PAIR_WAIT;
    logic [bpcq_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;

    combo_scoreboard            sb = new();
    bit                         rst_done = 1'b0;
    bit                         tx_burst = 1'b0;
    bit                         qual_on  = 1'b1;
    logic [bpcq_pkg::BTN_W-1:0] held     = '0;
    int                         combo_plan [6] = '{2, 255, 1, 0, 3, 8};
    int                         push_plan  [6] = '{0, 255, 3, 5, 1, 2};

    button_pair_combo_qualifier #(
        .NUM_BUTTONS (6)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #200000;
        $display("Some tests failed");
        $finish;
    end

    task send_scan(bpcq_pkg::t_in_item scan);
        int gap;
        if ($urandom_range(0, 29) == 0) begin
            tx_burst = !tx_burst;
        end
        gap = tx_burst ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= scan;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_scan(scan);
    endtask

    task scan(logic [bpcq_pkg::BTN_W-1:0] btn, logic layer,
              logic [bpcq_pkg::PAIR_W-1:0] pairs, logic qual);
        bpcq_pkg::t_in_item item;
        item.buttons        = btn;
        item.layer_changed  = layer;
        item.pair_enable    = pairs;
        item.qualify_enable = qual;
        send_scan(item);
    endtask

    task run_random(int count);
        bpcq_pkg::t_in_item item;
        int                 a;
        int                 b;
        repeat (count) begin
            if (qual_on) begin
                if ($urandom_range(0, 29) == 0) qual_on = 1'b0;
            end else if ($urandom_range(0, 4) == 0) begin
                qual_on = 1'b1;
            end
            case ($urandom_range(0, 9))
                0: held = bpcq_pkg::BTN_W'($urandom_range(0, 63));
                1: begin
                    a = $urandom_range(0, bpcq_pkg::BTN_W - 1);
                    b = (a + $urandom_range(1, bpcq_pkg::BTN_W - 1)) % bpcq_pkg::BTN_W;
                    held[a] = 1'b1;
                    held[b] = 1'b1;
                end
                2: held = '0;
                default: begin
                    for (int i = 0; i < bpcq_pkg::BTN_W; i++) begin
                        if ($urandom_range(0, 5) == 0) held[i] = ~held[i];
                    end
                end
            endcase
            item.buttons        = held;
            item.layer_changed  = ($urandom_range(0, 15) == 0);
            item.qualify_enable = qual_on;
            case ($urandom_range(0, 4))
                0: item.pair_enable = '0;
                1: item.pair_enable = '1;
                2: item.pair_enable = bpcq_pkg::PAIR_W'(1) <<
                                      $urandom_range(0, bpcq_pkg::PAIR_W - 1);
                default: item.pair_enable = bpcq_pkg::PAIR_W'($urandom_range(0, 32767));
            endcase
            send_scan(item);
        end
    endtask

    task settle();
        i_in_valid <= 1'b0;
        while (sb.pending_reports.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task write_terms(logic [bpcq_pkg::CFG_DATA_W-1:0] combo,
                     logic [bpcq_pkg::CFG_DATA_W-1:0] push);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= bpcq_pkg::CFG_PAIR_WAIT;
        i_cfg_data <= combo;
        @(posedge i_clk);
        sb.set_reg(bpcq_pkg::CFG_PAIR_WAIT, combo);
        i_cfg_idx  <= bpcq_pkg::CFG_TAP_HOLD;
        i_cfg_data <= push;
        @(posedge i_clk);
        sb.set_reg(bpcq_pkg::CFG_TAP_HOLD, push);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        int results_seen;
        int stall;
        bit rx_burst;
        results_seen = 0;
        rx_burst     = 1'b0;
        do @(posedge i_clk); while (!rst_done);
        forever begin
            if ($urandom_range(0, 39) == 0) begin
                rx_burst = !rx_burst;
            end
            stall = rx_burst ? 0 : $urandom_range(0, 6);
            if (results_seen == 150) begin
                stall = 80;
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            sb.check_report(o_out_item);
            results_seen++;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        rst_done = 1'b1;

        scan(6'h00, 1'b1, '1, 1'b1);
        scan(6'h01, 1'b0, '0, 1'b1);
        scan(6'h01, 1'b0, '1, 1'b1);
        scan(6'h03, 1'b0, '0, 1'b1);
        scan(6'h02, 1'b0, '0, 1'b1);
        scan(6'h00, 1'b0, '0, 1'b1);
        scan(6'h04, 1'b0, '0, 1'b1);
        scan(6'h00, 1'b0, '0, 1'b1);
        scan(6'h00, 1'b0, '0, 1'b1);
        scan(6'h3F, 1'b0, '0, 1'b1);
        scan(6'h3F, 1'b0, '0, 1'b1);
        scan(6'h00, 1'b0, '0, 1'b1);
        scan(6'h08, 1'b0, '0, 1'b1);
        scan(6'h08, 1'b1, '0, 1'b1);
        scan(6'h3F, 1'b0, '0, 1'b1);
        scan(6'h2A, 1'b1, '1, 1'b0);
        scan(6'h15, 1'b0, '0, 1'b0);
        scan(6'h10, 1'b0, '0, 1'b1);
        scan(6'h10, 1'b1, 15'h5555, 1'b0);
        scan(6'h00, 1'b1, 15'h4000, 1'b1);
        scan(6'h30, 1'b0, '0, 1'b1);
        scan(6'h10, 1'b0, '0, 1'b1);
        scan(6'h00, 1'b0, '0, 1'b1);

        for (int ph = 0; ph < 6; ph++) begin
            settle();
            if (ph == 5) begin
                combo_plan[ph] = $urandom_range(2, 20);
                push_plan[ph]  = $urandom_range(0, 10);
            end
            write_terms(bpcq_pkg::CFG_DATA_W'(combo_plan[ph]),
                        bpcq_pkg::CFG_DATA_W'(push_plan[ph]));
            run_random(130);
        end
        settle();

        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/bpcq_pkg.sv
hw/rtl/bpcq_scan.sv
hw/rtl/button_pair_combo_qualifier.sv
dv/button_pair_combo_qualifier_tb.sv
